@@ hdl/mersenne_twister_generator_top_defines.svh @@
// Assertion macros used by the generator's engine module.
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define MTG_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("generator assertion failed");

`define MTG_ASSERT_NEVER(name, clk, rst, cond) \
   `MTG_ASSERT(name, clk, rst, !(cond))

`else

`define MTG_ASSERT(name, clk, rst, prop)

`define MTG_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

@@ hdl/mtg_pkg.sv @@
package mtg_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned STORE_LEN = 624;
   localparam int unsigned SHIFT_M   = 397;
   localparam int unsigned IDX_W     = $clog2(STORE_LEN);

   // The queue pointers wrap by overflow, so the depth is a power of two.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(STORE_LEN - 1);
   localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;
   localparam logic [WORD_W-1:0] LCG_MULT   = 32'd69069;
   localparam logic [WORD_W-1:0] SEED_RESET = 32'd4357;

   typedef enum logic {
      OP_DRAW,
      OP_RESEED
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_ISSUE,
      ST_CALC
   } state_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] value);
      logic [WORD_W-1:0] y;
      y = value;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

@@ hdl/mtg_req_if.sv @@
interface mtg_req_if;
   logic valid;
   logic ready;
   logic reseed;

   modport source (output valid, output reseed, input ready);
   modport sink (input valid, input reseed, output ready);
endinterface

@@ hdl/mtg_rsp_if.sv @@
interface mtg_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [mtg_pkg::WORD_W-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

@@ hdl/mersenne_twister_generator_top.sv @@
// 32-bit Mersenne Twister word generator.
// req_chan carries draw requests; reseed set in a word forces a refill of
// the state store from the seed register before that draw. rsp_chan returns
// one tempered 32-bit word per request, in request order.
// csr_wr_en/csr_wr_data write the seed register and mark the store unseeded;
// write it only while no draw is outstanding.
// With the store seeded, an accepted draw is queued and popped by the engine,
// which reads the store (registered read) in ST_ISSUE, then twists, writes
// back and tempers in ST_CALC into the output register for rsp_chan; each
// draw starts only after the one before has left ST_CALC. Seeding writes
// one store entry per cycle through the 69069 multiplier and happens on
// the first draw after reset, after a seed write, and on every reseed request.
// Reset clears the queue, the output valid flag and the seeded flag and loads
// the seed register with 4357; the store itself is not cleared.
// When the receiver stalls, the result is held in the output register, the
// engine waits, and a two-entry queue keeps accepting requests until full.
module mersenne_twister_generator_top (
   input  logic                       clock,
   input  logic                       reset,
   mtg_req_if.sink                    req_chan,
   mtg_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [mtg_pkg::WORD_W-1:0] csr_wr_data
);

   logic [mtg_pkg::WORD_W-1:0] seed_ff, seed_in;
   mtg_pkg::head_type           head;
   logic                        pop;

   assign seed_in = csr_wr_en ? csr_wr_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mtg_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mtg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   mtg_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .seed         (seed_ff),
      .seed_written (csr_wr_en),
      .rsp_chan     (rsp_chan)
   );

endmodule

@@ hdl/mtg_ram.sv @@
module mtg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ hdl/mtg_front.sv @@
module mtg_front (
   input  logic              clock,
   input  logic              reset,
   mtg_req_if.sink           req_chan,
   input  logic              pop,
   output mtg_pkg::head_type head
);

   mtg_pkg::op_type             q_ff [mtg_pkg::QUEUE_DEPTH];
   logic [mtg_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mtg_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mtg_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        push;
   mtg_pkg::op_type             push_op;

   assign req_chan.ready = (count_ff != mtg_pkg::QCNT_W'(mtg_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign push_op        = req_chan.reseed ? mtg_pkg::OP_RESEED : mtg_pkg::OP_DRAW;

   assign head.valid = (count_ff != '0);
   assign head.op    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + mtg_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + mtg_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + mtg_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mtg_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ hdl/mtg_engine.sv @@
`include "mersenne_twister_generator_top_defines.svh"

module mtg_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  mtg_pkg::head_type          head,
   output logic                       pop,
   input  logic [mtg_pkg::WORD_W-1:0] seed,
   input  logic                       seed_written,
   mtg_rsp_if.source                  rsp_chan
);

   mtg_pkg::state_type          state_ff, state_in;
   logic [mtg_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [mtg_pkg::IDX_W-1:0]  fill_ff, fill_in;
   logic [mtg_pkg::WORD_W-1:0] lcg_ff, lcg_in;
   logic [mtg_pkg::WORD_W-1:0] cur_ff, cur_in;
   logic                        seeded_ff, seeded_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mtg_pkg::WORD_W-1:0] rsp_word_ff, rsp_word_in;

   logic                        wr_en;
   logic [mtg_pkg::IDX_W-1:0]  wr_addr;
   logic [mtg_pkg::WORD_W-1:0] wr_data;
   logic [mtg_pkg::IDX_W-1:0]  nxt_addr;
   logic [mtg_pkg::IDX_W-1:0]  far_addr;
   logic [mtg_pkg::IDX_W:0]    far_sum;
   logic [mtg_pkg::WORD_W-1:0] nxt_data;
   logic [mtg_pkg::WORD_W-1:0] far_data;
   logic [mtg_pkg::WORD_W-1:0] mix;
   logic [mtg_pkg::WORD_W-1:0] twisted;
   logic                        out_free;
   logic                        need_seed;

   // Read addresses follow the current position; the entry after it and
   // the one SHIFT_M ahead are read from two copies of the store.
   assign nxt_addr = (idx_ff == mtg_pkg::LAST_IDX) ? '0 : idx_ff + mtg_pkg::IDX_W'(1);
   assign far_sum  = (mtg_pkg::IDX_W+1)'(idx_ff) + (mtg_pkg::IDX_W+1)'(mtg_pkg::SHIFT_M);
   assign far_addr = (far_sum >= (mtg_pkg::IDX_W+1)'(mtg_pkg::STORE_LEN))
                   ? mtg_pkg::IDX_W'(far_sum - (mtg_pkg::IDX_W+1)'(mtg_pkg::STORE_LEN))
                   : mtg_pkg::IDX_W'(far_sum);

   mtg_ram #(
      .WIDTH (mtg_pkg::WORD_W),
      .DEPTH (mtg_pkg::STORE_LEN)
   ) u_ram_nxt (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (nxt_addr),
      .rd_data_ff (nxt_data)
   );

   mtg_ram #(
      .WIDTH (mtg_pkg::WORD_W),
      .DEPTH (mtg_pkg::STORE_LEN)
   ) u_ram_far (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (far_addr),
      .rd_data_ff (far_data)
   );

   // Twisting in place, one entry per draw, matches a whole-store twist:
   // entries ahead are still old, entries behind are already new.
   assign mix     = {cur_ff[mtg_pkg::WORD_W-1], nxt_data[mtg_pkg::WORD_W-2:0]};
   assign twisted = far_data ^ (mix >> 1) ^ (mix[0] ? mtg_pkg::TWIST_XOR : '0);

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign need_seed = (head.op == mtg_pkg::OP_RESEED) || !seeded_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      lcg_in       = lcg_ff;
      cur_in       = cur_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = twisted;

      unique case (state_ff)
         mtg_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (need_seed) begin
                  state_in = mtg_pkg::ST_SEED;
                  fill_in  = '0;
                  lcg_in   = seed;
                  cur_in   = seed;
               end else begin
                  state_in = mtg_pkg::ST_ISSUE;
               end
            end
         end
         mtg_pkg::ST_SEED: begin
            wr_en   = 1'b1;
            wr_addr = fill_ff;
            wr_data = lcg_ff;
            lcg_in  = lcg_ff * mtg_pkg::LCG_MULT;
            fill_in = fill_ff + mtg_pkg::IDX_W'(1);
            if (fill_ff == mtg_pkg::LAST_IDX) begin
               state_in  = mtg_pkg::ST_ISSUE;
               seeded_in = 1'b1;
               idx_in    = '0;
            end
         end
         mtg_pkg::ST_ISSUE: begin
            state_in = mtg_pkg::ST_CALC;
         end
         mtg_pkg::ST_CALC: begin
            if (out_free) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_word_in  = mtg_pkg::temper(twisted);
               cur_in       = nxt_data;
               idx_in       = nxt_addr;
               if (head.valid) begin
                  pop = 1'b1;
                  if (need_seed) begin
                     state_in = mtg_pkg::ST_SEED;
                     fill_in  = '0;
                     lcg_in   = seed;
                     cur_in   = seed;
                  end else begin
                     state_in = mtg_pkg::ST_ISSUE;
                  end
               end else begin
                  state_in = mtg_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mtg_pkg::ST_IDLE;
         end
      endcase

      if (seed_written) begin
         seeded_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtg_pkg::ST_IDLE;
         idx_ff       <= '0;
         fill_ff      <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lcg_ff      <= lcg_in;
      cur_ff      <= cur_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.random_word = rsp_word_ff;

   `MTG_ASSERT(a_idx_range, clock, reset,
      idx_ff <= mtg_pkg::LAST_IDX)
   `MTG_ASSERT(a_pop_needs_item, clock, reset,
      pop |-> head.valid)
   `MTG_ASSERT(a_stall_holds_calc, clock, reset,
      (state_ff == mtg_pkg::ST_CALC && rsp_valid_ff && !rsp_chan.ready)
         |=> (state_ff == mtg_pkg::ST_CALC))
   `MTG_ASSERT(a_seed_restarts_round, clock, reset,
      ($past(state_ff) == mtg_pkg::ST_SEED && state_ff == mtg_pkg::ST_ISSUE)
         |-> (idx_ff == '0))

endmodule

@@ verif/mtg_word_checker.sv @@
`timescale 1ns / 1ps

module mtg_word_checker
   import mtg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   mtg_req_if                req_chan,
   mtg_rsp_if                rsp_chan,
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                words_pending
);

   localparam logic [IDX_W-1:0]  UNSEEDED  = IDX_W'(STORE_LEN + 1);
   localparam logic [WORD_W-1:0] HIGH_BIT  = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LOW_BITS  = 32'h7fff_ffff;

   logic [WORD_W-1:0] state_words [STORE_LEN];
   logic [IDX_W-1:0]  word_pos;
   logic [WORD_W-1:0] seed_value;
   logic [WORD_W-1:0] expected_words [$];
   int                fail_total = 0;

   assign fail_count = fail_total;

   initial words_pending = 0;

   task automatic fill_store;
      state_words[0] = seed_value;
      for (int i = 1; i < STORE_LEN; i++)
         state_words[i] = state_words[i-1] * LCG_MULT;
      word_pos = IDX_W'(STORE_LEN);
   endtask

   // The store is rewritten in place, so the last entries already see the
   // new values of the first ones, as the scheme requires.
   task automatic twist_store;
      logic [WORD_W-1:0] mixed;
      logic [WORD_W-1:0] fresh;
      int                nxt_k;
      int                far_k;
      for (int k = 0; k < STORE_LEN; k++) begin
         nxt_k = (k + 1) % STORE_LEN;
         far_k = (k + SHIFT_M) % STORE_LEN;
         mixed = (state_words[k] & HIGH_BIT) | (state_words[nxt_k] & LOW_BITS);
         fresh = state_words[far_k] ^ (mixed >> 1);
         if (mixed[0]) begin
            fresh = fresh ^ TWIST_XOR;
         end
         state_words[k] = fresh;
      end
      word_pos = '0;
   endtask

   function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] raw);
      logic [WORD_W-1:0] t;
      t = raw ^ (raw >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      return t ^ (t >> 18);
   endfunction

   task automatic draw_next_word(input op_type op, output logic [WORD_W-1:0] word);
      if (op == OP_RESEED) begin
         word_pos = UNSEEDED;
      end
      if (word_pos > STORE_LEN) begin
         fill_store();
      end
      if (word_pos >= STORE_LEN) begin
         twist_store();
      end
      word = tempered(state_words[word_pos]);
      word_pos = word_pos + 1'b1;
   endtask

   always @(posedge clock) begin
      logic [WORD_W-1:0] want;
      if (reset) begin
         word_pos = UNSEEDED;
         seed_value = SEED_RESET;
         expected_words.delete();
      end else begin
         if (csr_wr_en) begin
            seed_value = csr_wr_data;
            word_pos = UNSEEDED;
         end
         // Results are retired before new draws so that a stray word can
         // never pair up with a request accepted at the same edge.
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_words.size() == 0) begin
               $error("random_word arrived with no draw outstanding: actual %h",
                      rsp_chan.random_word);
               fail_total++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_chan.random_word !== want) begin
                  $error("random_word mismatch: expected %h, actual %h",
                         want, rsp_chan.random_word);
                  fail_total++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            draw_next_word(op_type'(req_chan.reseed), want);
            expected_words = {expected_words, want};
         end
      end
      words_pending <= expected_words.size();
   end

endmodule

@@ verif/tb_mersenne_twister_generator_top.sv @@
`timescale 1ns / 1ps

module tb_mersenne_twister_generator_top;
   import mtg_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [WORD_W-1:0] csr_wr_data;
   logic              steady_run;
   int                fail_count;
   int                words_pending;
   int unsigned       cycle_count = 0;

   mtg_req_if req_if ();
   mtg_rsp_if rsp_if ();

   mersenne_twister_generator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mtg_word_checker word_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_if),
      .rsp_chan      (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= steady_run || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_mersenne_twister_generator_top failed");
         $finish;
      end
   end

   task automatic send_draw(input op_type op);
      while (!steady_run && $urandom_range(99) < 28) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.reseed <= op;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // The first edge lets the count catch up with a word accepted just now.
   task automatic drain_results;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_seed(input logic [WORD_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [WORD_W-1:0] phase_seed;
      int                phase_len;
      int                reseed_pct;
      req_if.valid  = 1'b0;
      req_if.reseed = 1'b0;
      rsp_if.ready  = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      steady_run    = 1'b0;
      reset         = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // First draws seed from the reset value, then a reseed with the
      // register untouched must restart the same sequence.
      repeat (3) send_draw(OP_DRAW);
      send_draw(OP_RESEED);
      repeat (2) send_draw(OP_DRAW);

      // A zero seed gives a store of zeros and nothing but zero words.
      write_seed('0);
      repeat (2) send_draw(OP_DRAW);
      send_draw(OP_RESEED);
      send_draw(OP_DRAW);

      write_seed('1);
      repeat (2) send_draw(OP_DRAW);
      send_draw(OP_RESEED);
      send_draw(OP_RESEED);
      send_draw(OP_DRAW);

      write_seed(32'd1);
      repeat (2) send_draw(OP_DRAW);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               phase_seed = $urandom();
               phase_len  = 700;
               reseed_pct = 0;
            end
            1: begin
               phase_seed = '1;
               phase_len  = 140;
               reseed_pct = 4;
            end
            2: begin
               phase_seed = '0;
               phase_len  = 60;
               reseed_pct = 4;
            end
            3: begin
               phase_seed = SEED_RESET;
               phase_len  = 140;
               reseed_pct = 4;
            end
            4: begin
               phase_seed = $urandom();
               phase_len  = 180;
               reseed_pct = 5;
            end
            default: begin
               phase_seed = $urandom();
               phase_len  = 180;
               reseed_pct = 3;
            end
         endcase
         write_seed(phase_seed);
         // The long phase runs past a full twist of the store; its opening
         // stretch goes with no idling on either side.
         for (int n = 0; n < phase_len; n++) begin
            steady_run <= (p == 0) && (n < 300);
            if (p != 0 && $urandom_range(199) == 0) begin
               drain_results();
            end
            send_draw(($urandom_range(99) < reseed_pct) ? OP_RESEED : OP_DRAW);
         end
      end

      steady_run <= 1'b0;
      drain_results();
      if (fail_count == 0) begin
         $display("tb_mersenne_twister_generator_top passed");
      end else begin
         $display("tb_mersenne_twister_generator_top failed");
      end
      $finish;
   end

endmodule
